/* rtl/bank_mapper_with_scanline_irq_unit_assert.svh */
// Assertion macros shared by the mapper RTL.
`ifndef BANK_MAPPER_WITH_SCANLINE_IRQ_UNIT_ASSERT_SVH
`define BANK_MAPPER_WITH_SCANLINE_IRQ_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while in reset.
`define BMSIRQ_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("mapper assertion failed");

// Next-cycle implication, sampled on clk and disabled while in reset.
`define BMSIRQ_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("mapper assertion failed");

`endif

/* rtl/bmsirq_pkg.sv */
`default_nettype none

package bmsirq_pkg;

    // Bus transaction kinds.
    typedef enum logic [1:0] {
        ACT_CPU_READ  = 2'd0,
        ACT_CPU_WRITE = 2'd1,
        ACT_PPU_READ  = 2'd2,
        ACT_PPU_WRITE = 2'd3
    } action_t;

    // Memory that an access lands in.
    typedef enum logic [2:0] {
        TGT_NONE      = 3'd0,
        TGT_PRG_ROM   = 3'd1,
        TGT_PATTERN   = 3'd2,
        TGT_SAVE_RAM  = 3'd3,
        TGT_EXPANSION = 3'd4,
        TGT_NAMETABLE = 3'd5
    } target_t;

    // Configuration register indexes.
    localparam logic CFG_PRG_ROM_BANKS = 1'b0;
    localparam logic CFG_CHR_IS_RAM    = 1'b1;

    // Mapper register groups, decoded from CPU address bits 14..13.
    localparam logic [1:0] REG_BANK           = 2'd0;
    localparam logic [1:0] REG_MIRROR_PROTECT = 2'd1;
    localparam logic [1:0] REG_IRQ_RELOAD     = 2'd2;
    localparam logic [1:0] REG_IRQ_ENABLE     = 2'd3;

    localparam int CFG_DATA_W  = 6;
    localparam int OFFSET_W    = 19;

    // Reset values of the configuration registers.
    localparam logic [CFG_DATA_W-1:0] PRG_ROM_BANKS_RESET = 6'd2;
    localparam logic                  CHR_IS_RAM_RESET    = 1'b0;

    // Parameter defaults.
    localparam int PRG_OFFSET_BITS_DEFAULT   = 19;
    localparam int A12_FILTER_CYCLES_DEFAULT = 3;

    // CPU address map.
    localparam logic [15:0] CPU_EXP_BASE  = 16'h4020;
    localparam logic [15:0] CPU_SRAM_BASE = 16'h6000;
    localparam logic [15:0] CPU_REG_BASE  = 16'h8000;

    // PPU address map.
    localparam logic [15:0] PPU_CHR_TOP = 16'h1FFF;
    localparam logic [15:0] PPU_NT_TOP  = 16'h3EFF;

endpackage

`default_nettype wire

/* rtl/bank_mapper_with_scanline_irq_unit.sv */
`default_nettype none

// Bank-switching cartridge mapper with a scanline interrupt counter.
// Input channel (in_valid/in_stall): one CPU or PPU bus access per transaction,
// carrying action, bus_address, write_data and cpu_cycle.
// Output channel (out_valid/out_stall): one result per access with target,
// offset, accepted and irq_raised, in the order the accesses came in.
// A transaction is taken on a rising edge where valid is high and stall is low.
// An accepted access lands in an input register; an edge on which the result register
// is free translates it, updates the mapper registers and the A12 counter, and loads
// the result register, where the result stays on the output until it is taken.
// Throughput is one access per cycle while out_stall stays low: translation and the
// counter update are a single pass of logic between the input and result registers.
// When the receiver stalls, the result register holds and the input register
// can still fill, so one more access is taken before in_stall rises.
// The cfg port (cfg_en, cfg_index, cfg_data) writes prg_rom_banks (index 0)
// and chr_is_ram (index 1); write it only while no access is in flight.
// Reset clears all mapper registers and the counter, empties both registers,
// and sets prg_rom_banks to 2 and chr_is_ram to 0.
module bank_mapper_with_scanline_irq_unit #(
    parameter int PRG_OFFSET_BITS   = bmsirq_pkg::PRG_OFFSET_BITS_DEFAULT,
    parameter int A12_FILTER_CYCLES = bmsirq_pkg::A12_FILTER_CYCLES_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                cfg_en,
    input  wire logic                                cfg_index,
    input  wire logic [bmsirq_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  wire logic                                in_valid,
    output      logic                                in_stall,
    input  wire logic [1:0]                          action,
    input  wire logic [15:0]                         bus_address,
    input  wire logic [7:0]                          write_data,
    input  wire logic [31:0]                         cpu_cycle,

    output      logic                                out_valid,
    input  wire logic                                out_stall,
    output      logic [2:0]                          target,
    output      logic [bmsirq_pkg::OFFSET_W-1:0]     offset,
    output      logic                                accepted,
    output      logic                                irq_raised
);

    localparam int PRG_FULL_W = 20;
    localparam logic [PRG_FULL_W-1:0] PRG_MASK =
        (PRG_OFFSET_BITS >= PRG_FULL_W) ? {PRG_FULL_W{1'b1}}
                                        : PRG_FULL_W'((64'd1 << PRG_OFFSET_BITS) - 64'd1);

    // Configuration registers.
    logic [bmsirq_pkg::CFG_DATA_W-1:0] prg_rom_banks_reg;
    logic                              chr_is_ram_reg;

    // Mapper state.
    logic [7:0]  bank_select_reg,    bank_select_next;
    logic [7:0]  bank_values_reg [8];
    logic [7:0]  bank_values_next [8];
    logic [7:0]  ram_protect_reg,    ram_protect_next;
    logic [7:0]  mirror_mode_reg,    mirror_mode_next;
    logic [7:0]  irq_reload_reg,     irq_reload_next;
    logic [7:0]  scanline_count_reg, scanline_count_next;
    logic        irq_enabled_reg,    irq_enabled_next;
    logic        a12_low_reg,        a12_low_next;
    logic [31:0] a12_fall_cycle_reg, a12_fall_cycle_next;

    // Input register.
    logic        s1_valid_reg;
    logic [1:0]  s1_action_reg;
    logic [15:0] s1_address_reg;
    logic [7:0]  s1_data_reg;
    logic [31:0] s1_cycle_reg;

    // Result register.
    logic                            out_valid_reg;
    bmsirq_pkg::target_t             target_reg,     target_next;
    logic [bmsirq_pkg::OFFSET_W-1:0] offset_reg,     offset_next;
    logic                            accepted_reg,   accepted_next;
    logic                            irq_raised_reg, irq_raised_next;

    // Handshake.
    logic out_ready;
    logic process;
    logic in_fire;

    // Address translation.
    logic [15:0]           a;
    logic [PRG_FULL_W-1:0] prg_last;
    logic [PRG_FULL_W-1:0] prg_r6;
    logic [PRG_FULL_W-1:0] prg_r7;
    logic [PRG_FULL_W-1:0] prg_full;
    logic [PRG_FULL_W-1:0] prg_masked;
    logic [2:0]            chr_slot;
    logic [2:0]            chr_idx;
    logic [7:0]            chr_bank;
    logic [17:0]           chr_off;
    logic [11:0]           nt_off;
    logic                  exp_ok;
    logic [31:0]           cycle_diff;
    logic                  filter_pass;
    logic [7:0]            count_clocked;

    // The result register frees when it is empty or being taken.
    assign out_ready = !out_valid_reg || !out_stall;
    assign process   = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign in_fire   = in_valid && !in_stall;

    assign a = s1_address_reg;

    // Program ROM: two switchable 8 KiB banks and the last two fixed ones.
    always_comb
    begin
        prg_last = {prg_rom_banks_reg - 6'd1, 14'b0};
        prg_r6   = {1'b0, bank_values_reg[6][5:0], 13'b0};
        prg_r7   = {1'b0, bank_values_reg[7][5:0], 13'b0};
        unique case (a[14:13])
            2'd0:    prg_full = (bank_select_reg[6] ? prg_last : prg_r6) + {7'b0, a[12:0]};
            2'd1:    prg_full = prg_r7 + {7'b0, a[12:0]};
            2'd2:    prg_full = (bank_select_reg[6] ? prg_r6 : prg_last) + {7'b0, a[12:0]};
            default: prg_full = prg_last + {6'b0, a[13:0]};
        endcase
        prg_masked = prg_full & PRG_MASK;
    end

    // Pattern memory: two 2 KiB pair banks and four 1 KiB banks, swappable halves.
    always_comb
    begin
        chr_slot = a[12:10] ^ {bank_select_reg[7], 2'b00};
        chr_idx  = chr_slot[2] ? ({1'b0, chr_slot[1:0]} + 3'd2) : {2'b00, chr_slot[1]};
        chr_bank = bank_values_reg[chr_idx];
        chr_off  = chr_slot[2] ? {chr_bank, a[9:0]} : {chr_bank[7:1], a[10:0]};
    end

    // Nametables: horizontal or vertical mirroring.
    always_comb
    begin
        if (mirror_mode_reg[0])
        begin
            nt_off = a[11] ? {a[11], 1'b0, a[9:0]} : {2'b00, a[9:0]};
        end
        else
        begin
            nt_off = {1'b0, a[10:0]};
        end
    end

    // A12 edge filter and the next count value on a counter clock.
    always_comb
    begin
        cycle_diff    = s1_cycle_reg - a12_fall_cycle_reg;
        filter_pass   = (s1_cycle_reg < a12_fall_cycle_reg)
                        || (cycle_diff >= 32'(A12_FILTER_CYCLES));
        count_clocked = (scanline_count_reg == 8'd0) ? irq_reload_reg
                                                     : scanline_count_reg - 8'd1;
        exp_ok        = ram_protect_reg[7]
                        && ((s1_action_reg == bmsirq_pkg::ACT_CPU_READ)
                            || ram_protect_reg[6] || ram_protect_reg[5]);
    end

    // Access decode, register writes and result.
    always_comb
    begin
        bank_select_next    = bank_select_reg;
        bank_values_next    = bank_values_reg;
        ram_protect_next    = ram_protect_reg;
        mirror_mode_next    = mirror_mode_reg;
        irq_reload_next     = irq_reload_reg;
        scanline_count_next = scanline_count_reg;
        irq_enabled_next    = irq_enabled_reg;
        a12_low_next        = a12_low_reg;
        a12_fall_cycle_next = a12_fall_cycle_reg;
        target_next         = bmsirq_pkg::TGT_NONE;
        offset_next         = '0;
        accepted_next       = 1'b0;
        irq_raised_next     = 1'b0;

        unique case (bmsirq_pkg::action_t'(s1_action_reg))
            bmsirq_pkg::ACT_CPU_READ,
            bmsirq_pkg::ACT_CPU_WRITE:
            begin
                priority if (a < bmsirq_pkg::CPU_EXP_BASE)
                begin
                    target_next = bmsirq_pkg::TGT_NONE;
                end
                else if (a < bmsirq_pkg::CPU_SRAM_BASE)
                begin
                    if (exp_ok)
                    begin
                        target_next   = bmsirq_pkg::TGT_EXPANSION;
                        offset_next   = 19'(a - bmsirq_pkg::CPU_EXP_BASE);
                        accepted_next = s1_action_reg[0];
                    end
                end
                else if (a < bmsirq_pkg::CPU_REG_BASE)
                begin
                    target_next   = bmsirq_pkg::TGT_SAVE_RAM;
                    offset_next   = {6'b0, a[12:0]};
                    accepted_next = s1_action_reg[0];
                end
                else if (s1_action_reg == bmsirq_pkg::ACT_CPU_READ)
                begin
                    target_next = bmsirq_pkg::TGT_PRG_ROM;
                    offset_next = prg_masked[bmsirq_pkg::OFFSET_W-1:0];
                end
                else
                begin
                    // Register write: address bits 14..13 and bit 0 pick the register.
                    accepted_next = 1'b1;
                    unique case (a[14:13])
                        bmsirq_pkg::REG_BANK:
                        begin
                            if (a[0])
                                bank_values_next[bank_select_reg[2:0]] = s1_data_reg;
                            else
                                bank_select_next = s1_data_reg;
                        end
                        bmsirq_pkg::REG_MIRROR_PROTECT:
                        begin
                            if (a[0])
                                ram_protect_next = s1_data_reg;
                            else
                                mirror_mode_next = s1_data_reg;
                        end
                        bmsirq_pkg::REG_IRQ_RELOAD:
                        begin
                            if (a[0])
                                scanline_count_next = 8'd0;
                            else
                                irq_reload_next = s1_data_reg;
                        end
                        bmsirq_pkg::REG_IRQ_ENABLE:
                        begin
                            irq_enabled_next = a[0];
                        end
                    endcase
                end
            end

            bmsirq_pkg::ACT_PPU_READ:
            begin
                // Only pattern-table reads drive the A12 filter.
                if (a[15:13] == 3'd0)
                begin
                    if (!a[12])
                    begin
                        if (!a12_low_reg)
                        begin
                            a12_low_next        = 1'b1;
                            a12_fall_cycle_next = s1_cycle_reg;
                        end
                    end
                    else if (a12_low_reg)
                    begin
                        a12_low_next = 1'b0;
                        if (filter_pass)
                        begin
                            scanline_count_next = count_clocked;
                            irq_raised_next     = (count_clocked == 8'd0) && irq_enabled_reg;
                        end
                    end
                end
                priority if (a <= bmsirq_pkg::PPU_CHR_TOP)
                begin
                    target_next = bmsirq_pkg::TGT_PATTERN;
                    offset_next = {1'b0, chr_off};
                end
                else if (a <= bmsirq_pkg::PPU_NT_TOP)
                begin
                    target_next = bmsirq_pkg::TGT_NAMETABLE;
                    offset_next = {7'b0, nt_off};
                end
                else
                begin
                    target_next = bmsirq_pkg::TGT_NONE;
                end
            end

            bmsirq_pkg::ACT_PPU_WRITE:
            begin
                priority if (a <= bmsirq_pkg::PPU_CHR_TOP)
                begin
                    // Pattern ROM is not writable.
                    if (chr_is_ram_reg)
                    begin
                        target_next   = bmsirq_pkg::TGT_PATTERN;
                        offset_next   = {1'b0, chr_off};
                        accepted_next = 1'b1;
                    end
                end
                else if (a <= bmsirq_pkg::PPU_NT_TOP)
                begin
                    target_next   = bmsirq_pkg::TGT_NAMETABLE;
                    offset_next   = {7'b0, nt_off};
                    accepted_next = 1'b1;
                end
                else
                begin
                    target_next = bmsirq_pkg::TGT_NONE;
                end
            end

            default:
            begin
                target_next = bmsirq_pkg::TGT_NONE;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_rom_banks_reg <= bmsirq_pkg::PRG_ROM_BANKS_RESET;
            chr_is_ram_reg    <= bmsirq_pkg::CHR_IS_RAM_RESET;
        end
        else if (cfg_en)
        begin
            unique case (cfg_index)
                bmsirq_pkg::CFG_PRG_ROM_BANKS: prg_rom_banks_reg <= cfg_data;
                bmsirq_pkg::CFG_CHR_IS_RAM:    chr_is_ram_reg    <= cfg_data[0];
                default:                       prg_rom_banks_reg <= prg_rom_banks_reg;
            endcase
        end
    end

    // Mapper state advances once per processed transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_select_reg    <= '0;
            bank_values_reg    <= '{default: '0};
            ram_protect_reg    <= '0;
            mirror_mode_reg    <= '0;
            irq_reload_reg     <= '0;
            scanline_count_reg <= '0;
            irq_enabled_reg    <= 1'b0;
            a12_low_reg        <= 1'b0;
            a12_fall_cycle_reg <= '0;
        end
        else if (process)
        begin
            bank_select_reg    <= bank_select_next;
            bank_values_reg    <= bank_values_next;
            ram_protect_reg    <= ram_protect_next;
            mirror_mode_reg    <= mirror_mode_next;
            irq_reload_reg     <= irq_reload_next;
            scanline_count_reg <= scanline_count_next;
            irq_enabled_reg    <= irq_enabled_next;
            a12_low_reg        <= a12_low_next;
            a12_fall_cycle_reg <= a12_fall_cycle_next;
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_action_reg  <= action;
            s1_address_reg <= bus_address;
            s1_data_reg    <= write_data;
            s1_cycle_reg   <= cpu_cycle;
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (process)
        begin
            target_reg     <= target_next;
            offset_reg     <= offset_next;
            accepted_reg   <= accepted_next;
            irq_raised_reg <= irq_raised_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign target     = target_reg;
    assign offset     = offset_reg;
    assign accepted   = accepted_reg;
    assign irq_raised = irq_raised_reg;

`include "bank_mapper_with_scanline_irq_unit_assert.svh"

    // An interrupt only comes from a pattern-table read.
    `BMSIRQ_ASSERT_NOW(a_irq_on_pattern,
        out_valid_reg && irq_raised_reg, target_reg == bmsirq_pkg::TGT_PATTERN)

    // A raised interrupt leaves the counter at zero with interrupts enabled.
    `BMSIRQ_ASSERT_NOW(a_irq_state,
        out_valid_reg && irq_raised_reg, irq_enabled_reg && (scanline_count_reg == 8'd0))

    // No target means no offset.
    `BMSIRQ_ASSERT_NOW(a_none_zero_offset,
        out_valid_reg && (target_reg == bmsirq_pkg::TGT_NONE), offset_reg == '0)

    // Program ROM is read-only.
    `BMSIRQ_ASSERT_NOW(a_prg_not_written,
        out_valid_reg && (target_reg == bmsirq_pkg::TGT_PRG_ROM), !accepted_reg)

    // A held access is not dropped while the result register is stalled.
    `BMSIRQ_ASSERT_NEXT(a_hold_input,
        s1_valid_reg && out_valid_reg && out_stall, s1_valid_reg)

endmodule

`default_nettype wire
